// ===== rtl/b2d_pkg.sv =====
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared types and constants for the binary to decimal digit serializer.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int DIGIT_W        = 4;

    // controller to datapath
    typedef struct packed {
        logic load;    // take a new value, clear digits
        logic dabble;  // one double-dabble step
        logic drop;    // discard a leading zero digit
        logic emit;    // move top digit into the output register
    } b2d_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cnt_last;  // counter on its final step
        logic top_zero;  // top digit is zero
        logic out_free;  // output register can take a beat
    } b2d_sts_t;

endpackage

// ===== rtl/b2d_ctrl.sv =====
// ----------------------------------------------------------------------------
// b2d_ctrl
// Sequencer: load, bit-serial conversion, leading zero skip, digit output.
// ----------------------------------------------------------------------------
module b2d_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  b2d_pkg::b2d_sts_t sts,
    output b2d_pkg::b2d_cmd_t cmd
);
    import b2d_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.dabble = 1'b1;
                if (sts.cnt_last) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // keep at least one digit so zero gives a single 0
                if (sts.top_zero && !sts.cnt_last) begin
                    cmd.drop = 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.cnt_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/b2d_dpath.sv =====
// ----------------------------------------------------------------------------
// b2d_dpath
// Shift register, BCD digit register, step counter and output register.
// ----------------------------------------------------------------------------
module b2d_dpath #(
    parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF,
    parameter int NUM_DIGITS = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [VALUE_BITS-1:0]          value,
    input  b2d_pkg::b2d_cmd_t              cmd,
    output b2d_pkg::b2d_sts_t              sts,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [b2d_pkg::DIGIT_W-1:0]    out_digit,
    output logic                           out_last
);
    import b2d_pkg::*;

    localparam int BCD_W = DIGIT_W * NUM_DIGITS;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] val_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  out_valid_reg;
    logic [DIGIT_W-1:0]    out_digit_reg;
    logic                  out_last_reg;
    logic [BCD_W-1:0]      bcd_adj;
    logic [DIGIT_W-1:0]    top_digit;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign top_digit    = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign sts.cnt_last = (cnt_reg == CNT_W'(1));
    assign sts.top_zero = (top_digit == '0);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg <= value;
            bcd_reg <= '0;
            cnt_reg <= CNT_W'(VALUE_BITS);
        end else if (cmd.dabble) begin
            val_reg <= {val_reg[VALUE_BITS-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_W-2:0], val_reg[VALUE_BITS-1]};
            // counter switches from bit steps to digit steps
            cnt_reg <= sts.cnt_last ? CNT_W'(NUM_DIGITS) : cnt_reg - CNT_W'(1);
        end else if (cmd.drop || cmd.emit) begin
            bcd_reg <= {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_digit_reg <= top_digit;
            out_last_reg  <= sts.cnt_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_digit = out_digit_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/binary_to_decimal_digit_serializer_top.sv =====
// Takes one unsigned VALUE_BITS-bit integer per input beat and sends its decimal
// digits most significant first, one digit per output beat, with tlast on the
// final digit; leading zeros are dropped and zero gives a single 0. One number
// is handled at a time: the beat is picked up, then a bit-serial double-dabble
// converts it, leading zeros are dropped one at a time, the first digit sent is
// settled on and the digits are sent. A new beat is taken while the last digit
// of the previous number still waits.
// ----------------------------------------------------------------------------
// binary_to_decimal_digit_serializer_top
// Binary to decimal digit serializer, stream in and stream out.
// ----------------------------------------------------------------------------
module binary_to_decimal_digit_serializer_top #(
    parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,   // [VALUE_BITS-1:0] value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [3:0] digit
    output logic                                m_tlast
);
    import b2d_pkg::*;

    // digits of 2^VALUE_BITS - 1, 1233/4096 standing in for log10(2)
    localparam int NUM_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;

    b2d_cmd_t           cmd;
    b2d_sts_t           sts;
    logic [DIGIT_W-1:0] digit;

    b2d_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    b2d_dpath #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .value     (s_tdata[VALUE_BITS-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_digit (digit),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(8-DIGIT_W){1'b0}}, digit};

    // a sent digit is always decimal
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= 4'd9))
        else $error("digit out of range");

    // one number at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken during conversion");

    // conversion takes cycles, so no digit right after a beat is taken
    a_no_early_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("digit sent before conversion");

endmodule
